>>> sv/biou_pkg.sv
package biou_pkg;

  // Default geometry: 12.4 coordinates, ratio with 16 fraction bits.
  localparam int CoordBitsDef = 16;
  localparam int RatioBitsDef = 16;

  // Pipeline depth in front of the divider: overlap (2) + area (2).
  localparam int FrontStages = 4;

endpackage

>>> sv/biou_overlap.sv
module biou_overlap import biou_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] ax_i,
  input  logic [COORD_BITS-1:0] ay_i,
  input  logic [COORD_BITS-1:0] aw_i,
  input  logic [COORD_BITS-1:0] ah_i,
  input  logic [COORD_BITS-1:0] bx_i,
  input  logic [COORD_BITS-1:0] by_i,
  input  logic [COORD_BITS-1:0] bw_i,
  input  logic [COORD_BITS-1:0] bh_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS:0]   iw_o,
  output logic [COORD_BITS:0]   ih_o,
  output logic [COORD_BITS-1:0] aw_o,
  output logic [COORD_BITS-1:0] ah_o,
  output logic [COORD_BITS-1:0] bw_o,
  output logic [COORD_BITS-1:0] bh_o
);

  // corners at doubled scale: -(2^C-1) .. 3*(2^C-1)
  localparam int SW = COORD_BITS + 3;

  function automatic logic signed [SW-1:0] corner_lo(logic [COORD_BITS-1:0] c,
                                                     logic [COORD_BITS-1:0] s);
    return signed'({2'b00, c, 1'b0}) - signed'({3'b000, s});
  endfunction

  function automatic logic signed [SW-1:0] corner_hi(logic [COORD_BITS-1:0] c,
                                                     logic [COORD_BITS-1:0] s);
    return signed'({2'b00, c, 1'b0}) + signed'({3'b000, s});
  endfunction

  logic v1_q, v2_q;
  logic adv1, adv2;

  logic signed [SW-1:0] lox_d, hix_d, loy_d, hiy_d;
  logic signed [SW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic [COORD_BITS-1:0] aw1_q, ah1_q, bw1_q, bh1_q;

  logic signed [SW:0]   dx, dy;
  logic [COORD_BITS:0]  iw_d, ih_d;
  logic [COORD_BITS:0]  iw_q, ih_q;
  logic [COORD_BITS-1:0] aw2_q, ah2_q, bw2_q, bh2_q;

  assign adv2       = ~v2_q | out_ready_i;
  assign adv1       = ~v1_q | adv2;
  assign in_ready_o = adv1;

  always_comb begin
    logic signed [SW-1:0] la, ha, lb, hb;
    la    = corner_lo(ax_i, aw_i);
    ha    = corner_hi(ax_i, aw_i);
    lb    = corner_lo(bx_i, bw_i);
    hb    = corner_hi(bx_i, bw_i);
    lox_d = (la > lb) ? la : lb;
    hix_d = (ha < hb) ? ha : hb;
    la    = corner_lo(ay_i, ah_i);
    ha    = corner_hi(ay_i, ah_i);
    lb    = corner_lo(by_i, bh_i);
    hb    = corner_hi(by_i, bh_i);
    loy_d = (la > lb) ? la : lb;
    hiy_d = (ha < hb) ? ha : hb;
  end

  // a positive extent never exceeds twice a size, so C+1 bits hold it
  assign dx   = $signed({hix_q[SW-1], hix_q}) - $signed({lox_q[SW-1], lox_q});
  assign dy   = $signed({hiy_q[SW-1], hiy_q}) - $signed({loy_q[SW-1], loy_q});
  assign iw_d = (dx > 0) ? dx[COORD_BITS:0] : '0;
  assign ih_d = (dy > 0) ? dy[COORD_BITS:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      lox_q <= lox_d;
      hix_q <= hix_d;
      loy_q <= loy_d;
      hiy_q <= hiy_d;
      aw1_q <= aw_i;
      ah1_q <= ah_i;
      bw1_q <= bw_i;
      bh1_q <= bh_i;
    end
    if (adv2 && v1_q) begin
      iw_q  <= iw_d;
      ih_q  <= ih_d;
      aw2_q <= aw1_q;
      ah2_q <= ah1_q;
      bw2_q <= bw1_q;
      bh2_q <= bh1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign iw_o        = iw_q;
  assign ih_o        = ih_q;
  assign aw_o        = aw2_q;
  assign ah_o        = ah2_q;
  assign bw_o        = bw2_q;
  assign bh_o        = bh2_q;

endmodule

>>> sv/biou_area.sv
module biou_area import biou_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_BITS:0]     iw_i,
  input  logic [COORD_BITS:0]     ih_i,
  input  logic [COORD_BITS-1:0]   aw_i,
  input  logic [COORD_BITS-1:0]   ah_i,
  input  logic [COORD_BITS-1:0]   bw_i,
  input  logic [COORD_BITS-1:0]   bh_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2*COORD_BITS+2:0] inter_o,
  output logic [2*COORD_BITS+2:0] uni_o,
  output logic                    empty_o
);

  localparam int PW = 2 * COORD_BITS;     // size product
  localparam int IW = 2 * COORD_BITS + 2; // overlap product
  localparam int UW = 2 * COORD_BITS + 3; // union

  logic v3_q, v4_q;
  logic adv3, adv4;

  logic [IW-1:0] inter3_q;
  logic [PW-1:0] pa_q, pb_q;
  logic [UW-1:0] uni_d, uni_q, inter4_q;
  logic          empty_q;

  assign adv4       = ~v4_q | out_ready_i;
  assign adv3       = ~v3_q | adv4;
  assign in_ready_o = adv3;

  // areas at doubled coordinates are four times the size products
  assign uni_d = {1'b0, pa_q, 2'b00} + {1'b0, pb_q, 2'b00} - {1'b0, inter3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv3) v3_q <= in_valid_i;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && in_valid_i) begin
      inter3_q <= iw_i * ih_i;
      pa_q     <= aw_i * ah_i;
      pb_q     <= bw_i * bh_i;
    end
    if (adv4 && v3_q) begin
      uni_q    <= uni_d;
      inter4_q <= {1'b0, inter3_q};
      empty_q  <= (uni_d == '0);
    end
  end

  assign out_valid_o = v4_q;
  assign inter_o     = inter4_q;
  assign uni_o       = uni_q;
  assign empty_o     = empty_q;

endmodule

>>> sv/biou_div.sv
module biou_div import biou_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int RATIO_BITS = RatioBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2*COORD_BITS+2:0] inter_i,
  input  logic [2*COORD_BITS+2:0] uni_i,
  input  logic                    empty_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [RATIO_BITS:0]     ratio_o,
  output logic                    empty_o
);

  localparam int UW = 2 * COORD_BITS + 3;
  localparam int NS = RATIO_BITS + 1; // integer bit, then one bit per stage

  logic [NS-1:0]     v_q;
  logic [NS:0]       adv;
  logic [UW-1:0]     rem_q [NS];
  logic [UW-1:0]     uni_q [NS];
  logic [RATIO_BITS:0] quo_q [NS];
  logic [NS-1:0]     empty_q;

  assign adv[NS]    = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          prev_valid;
    logic [UW-1:0] prev_uni;
    logic          prev_empty;
    logic [UW:0]   trial;
    logic [RATIO_BITS:0] prev_quo;
    logic          ge;
    logic [UW:0]   diff;

    if (k == 0) begin : g_first
      // no shift: inter never exceeds union, so this bit marks a full overlap
      assign prev_valid = in_valid_i;
      assign prev_uni   = uni_i;
      assign prev_empty = empty_i;
      assign trial      = {1'b0, inter_i};
      assign prev_quo   = '0;
    end else begin : g_next
      assign prev_valid = v_q[k-1];
      assign prev_uni   = uni_q[k-1];
      assign prev_empty = empty_q[k-1];
      assign trial      = {rem_q[k-1], 1'b0};
      assign prev_quo   = quo_q[k-1];
    end

    assign ge   = (trial >= {1'b0, prev_uni});
    assign diff = trial - {1'b0, prev_uni};
    assign adv[k] = ~v_q[k] | adv[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && prev_valid) begin
        rem_q[k]   <= ge ? diff[UW-1:0] : trial[UW-1:0];
        uni_q[k]   <= prev_uni;
        quo_q[k]   <= {prev_quo[RATIO_BITS-1:0], ge};
        empty_q[k] <= prev_empty;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign ratio_o     = empty_q[NS-1] ? '0 : quo_q[NS-1];
  assign empty_o     = empty_q[NS-1];

endmodule

>>> sv/box_iou.sv
// Intersection over union of two axis-aligned boxes.
// Input stream: one request per box pair on s_axis; tdata carries eight
// unsigned fixed-point fields (center x, center y, width, height of the
// first box, then of the second), each COORD_BITS wide.
// Output stream: one result per request on m_axis; tdata carries the
// ratio with RATIO_BITS fraction bits (1.0 = 2^RATIO_BITS, truncated),
// tuser flags a zero union, in which case the ratio reads 0.
// Pipeline from acceptance to m_axis_tvalid: two overlap stages, multiply
// and union stages, then one restoring-division stage per quotient bit.
// Throughput: one pair per clock while m_axis is not stalled; every stage is fully pipelined.
// Reset empties all stages; no result is pending afterwards.
// Backpressure: each stage holds its data while the next is full, so a
// stalled receiver fills the pipeline's bubbles first and then drops
// s_axis_tready; nothing is lost or repeated.
module box_iou import biou_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int RATIO_BITS = RatioBitsDef,
  localparam int InW  = 8 * COORD_BITS,
  localparam int OutW = ((RATIO_BITS + 1 + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // first_center_x, first_center_y, first_box_width, first_box_height,
  // second_center_x, second_center_y, second_box_width, second_box_height
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // overlap_ratio, zero padded
  output logic [OutW-1:0] m_axis_tdata,
  // empty_union
  output logic            m_axis_tuser
);

  localparam int C  = COORD_BITS;
  localparam int UW = 2 * COORD_BITS + 3;

  logic [C-1:0] ax, ay, aw, ah, bx, by, bw, bh;

  assign ax = s_axis_tdata[0*C +: C];
  assign ay = s_axis_tdata[1*C +: C];
  assign aw = s_axis_tdata[2*C +: C];
  assign ah = s_axis_tdata[3*C +: C];
  assign bx = s_axis_tdata[4*C +: C];
  assign by = s_axis_tdata[5*C +: C];
  assign bw = s_axis_tdata[6*C +: C];
  assign bh = s_axis_tdata[7*C +: C];

  logic         ov_valid, ov_ready;
  logic [C:0]   iw, ih;
  logic [C-1:0] aw2, ah2, bw2, bh2;

  logic          ar_valid, ar_ready;
  logic [UW-1:0] inter, uni;
  logic          empty;

  logic [RATIO_BITS:0] ratio;

  biou_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ax_i       (ax),
    .ay_i       (ay),
    .aw_i       (aw),
    .ah_i       (ah),
    .bx_i       (bx),
    .by_i       (by),
    .bw_i       (bw),
    .bh_i       (bh),
    .out_valid_o(ov_valid),
    .out_ready_i(ov_ready),
    .iw_o       (iw),
    .ih_o       (ih),
    .aw_o       (aw2),
    .ah_o       (ah2),
    .bw_o       (bw2),
    .bh_o       (bh2)
  );

  biou_area #(
    .COORD_BITS(COORD_BITS)
  ) u_area (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (ov_valid),
    .in_ready_o (ov_ready),
    .iw_i       (iw),
    .ih_i       (ih),
    .aw_i       (aw2),
    .ah_i       (ah2),
    .bw_i       (bw2),
    .bh_i       (bh2),
    .out_valid_o(ar_valid),
    .out_ready_i(ar_ready),
    .inter_o    (inter),
    .uni_o      (uni),
    .empty_o    (empty)
  );

  biou_div #(
    .COORD_BITS(COORD_BITS),
    .RATIO_BITS(RATIO_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (ar_valid),
    .in_ready_o (ar_ready),
    .inter_i    (inter),
    .uni_i      (uni),
    .empty_i    (empty),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ratio_o    (ratio),
    .empty_o    (m_axis_tuser)
  );

  assign m_axis_tdata = OutW'(ratio);

endmodule
